/* hdl/grid_blockage_overlap_index_core_defines.svh */
// Assertion macros for the grid blockage index RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GRID_BLOCKAGE_OVERLAP_INDEX_CORE_DEFINES_SVH
`define GRID_BLOCKAGE_OVERLAP_INDEX_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GBOI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gboi: implication check failed");

// Next-cycle implication, checked outside reset.
`define GBOI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gboi: next-cycle check failed");

`endif

/* hdl/gboi_pkg.sv */
// Package for the grid blockage index: defaults, codes and shared types.
// No dependencies.
package gboi_pkg;

    localparam int unsigned MAX_GRID_DEF   = 64;
    localparam int unsigned SLOTS_DEF      = 8;
    localparam int unsigned COORD_BITS_DEF = 32;
    localparam int unsigned OWNER_BITS_DEF = 16;

    localparam int unsigned SIZE_BITS     = 31;
    localparam int unsigned GRID_REG_BITS = 7;
    localparam int unsigned ADDR_BITS     = 5;
    localparam int unsigned APB_DW        = 32;

    localparam logic [GRID_REG_BITS-1:0] GRID_RESET = 7'd50;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        REG_DIE_X = 3'd0,
        REG_DIE_Y = 3'd1,
        REG_BIN_W = 3'd2,
        REG_BIN_H = 3'd3,
        REG_GRID  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* hdl/gboi_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
module gboi_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/gboi_div.sv */
// Restoring divider that yields a bin index clamped to [0, dim-1].
// One compare-subtract per cycle; depends on gboi_pkg.
module gboi_div import gboi_pkg::*; #(
    parameter int unsigned MAX_GRID = MAX_GRID_DEF,
    parameter int unsigned DW       = COORD_BITS_DEF + 1,
    localparam int unsigned IDX_W = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1,
    localparam int unsigned DIM_W = IDX_W + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [DW-1:0]  i_dividend,
    input  logic [SIZE_BITS-1:0]  i_divisor,
    input  logic [DIM_W-1:0]      i_dim,
    output t_div_sts              o_sts,
    output logic [IDX_W-1:0]      o_index
);

    localparam int unsigned TW = SIZE_BITS + IDX_W;
    localparam int unsigned CW = ((DW > TW) ? DW : TW) + 1;
    localparam int unsigned SW = $clog2(IDX_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_trial;
    logic [IDX_W-1:0]  r_q;

    logic [CW-1:0]     w_mag;
    logic [CW-1:0]     w_lim;
    logic              w_bit;

    assign w_mag = CW'(i_dividend[DW-2:0]);
    assign w_lim = CW'(i_divisor) << IDX_W;
    assign w_bit = (r_rem >= r_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_dividend[DW-1]) begin
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if (w_mag >= w_lim) begin
                    // saturate, the clamp below maps it to dim-1
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem   <= w_mag;
                    r_trial <= CW'(i_divisor) << (IDX_W - 1);
                    r_step  <= SW'(IDX_W);
                    r_q     <= '0;
                    r_busy  <= 1'b1;
                end
            end else if (r_busy) begin
                if (w_bit) begin
                    r_rem <= r_rem - r_trial;
                end
                r_q     <= IDX_W'({r_q, w_bit});
                r_trial <= r_trial >> 1;
                r_step  <= r_step - 1'b1;
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_index    = (DIM_W'(r_q) >= i_dim) ? IDX_W'(i_dim - 1'b1) : r_q;

endmodule

/* hdl/grid_blockage_overlap_index_core.sv */
// Insert: four index divisions, then an S_BRD and an S_BWR step for each bin of range.
// Query: two index divisions, the count read in S_QRD and S_QCNT, then one slot scanned
// per S_QCHK step; a macro query goes straight to the result. One item at a time;
// s_axis_tready returns in the cycle after the result load; a held result stalls.
// Reset is synchronous; afterwards a clearing pass over all MAX_GRID*MAX_GRID bins zeroes
// the bin counts, s_axis_tready stays low meanwhile; configuration is taken as ever.
module grid_blockage_overlap_index_core import gboi_pkg::*; #(
    parameter int unsigned MAX_GRID      = MAX_GRID_DEF,
    parameter int unsigned SLOTS_PER_BIN = SLOTS_DEF,
    parameter int unsigned COORD_BITS    = COORD_BITS_DEF,
    parameter int unsigned OWNER_BITS    = OWNER_BITS_DEF,
    localparam int unsigned IN_DW  = ((4 * COORD_BITS + OWNER_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_DW = ((OWNER_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    // input beats
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DW-1:0]     s_axis_tdata,  // x_low, y_low, x_high, y_high, owner_id
    input  logic [1:0]           s_axis_tuser,  // command, is_macro
    // result beats
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_DW-1:0]    m_axis_tdata,  // blocking_owner
    output logic [1:0]           m_axis_tuser   // hit, overflow
);

`include "grid_blockage_overlap_index_core_defines.svh"

    localparam int unsigned C       = COORD_BITS;
    localparam int unsigned IDX_W   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int unsigned DIM_W   = IDX_W + 1;
    localparam int unsigned DW      = C + 1;
    localparam int unsigned BB      = ((C > SIZE_BITS) ? C : SIZE_BITS) + IDX_W + 2;
    localparam int unsigned NBINS   = MAX_GRID * MAX_GRID;
    localparam int unsigned NPIECES = NBINS * SLOTS_PER_BIN;
    localparam int unsigned BIN_W   = (NBINS > 1) ? $clog2(NBINS) : 1;
    localparam int unsigned PIECE_W = (NPIECES > 1) ? $clog2(NPIECES) : 1;
    localparam int unsigned CNT_W   = $clog2(SLOTS_PER_BIN + 1);
    localparam int unsigned PW      = 4 * C + OWNER_BITS;

    localparam logic [1:0] DS_XL = 2'd0;
    localparam logic [1:0] DS_XH = 2'd1;
    localparam logic [1:0] DS_YL = 2'd2;
    localparam logic [1:0] DS_YH = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV, S_DWAIT, S_BASE, S_BRD, S_BWR,
        S_QRD, S_QCNT, S_QCHK, S_DONE
    } t_state;

    // configuration registers
    logic signed [C-1:0]       r_die_x, r_die_y;
    logic [SIZE_BITS-1:0]      r_bw, r_bh;
    logic [GRID_REG_BITS-1:0]  r_grid;

    t_state                    r_state;
    logic                      r_cmd;
    logic signed [C-1:0]       r_xl, r_yl, r_xh, r_yh, r_cx, r_cy;
    logic [OWNER_BITS-1:0]     r_owner;
    logic [1:0]                r_dsel;
    logic [IDX_W-1:0]          r_c0, r_c1, r_r0, r_r1, r_c, r_r;
    logic signed [BB-1:0]      r_bx0s, r_bx0, r_by0, r_bx1, r_by1;
    logic [CNT_W-1:0]          r_k, r_n;
    logic [BIN_W-1:0]          r_clr;
    logic                      r_hit, r_ovf;
    logic [OWNER_BITS-1:0]     r_who;
    logic                      r_o_valid, r_o_hit, r_o_ovf;
    logic [OWNER_BITS-1:0]     r_o_who;

    logic                      w_cfg_we;
    t_reg_idx                  w_ridx;
    logic [SIZE_BITS-1:0]      w_bw, w_bh;
    logic [DIM_W-1:0]          w_dim;
    logic signed [C-1:0]       w_in_xl, w_in_xh, w_in_yl, w_in_yh;
    logic signed [C:0]         w_sx, w_sy, w_sxr, w_syr;
    logic signed [C-1:0]       w_dcoord, w_ddie;
    logic signed [DW-1:0]      w_dividend;
    logic [SIZE_BITS-1:0]      w_divisor;
    logic                      w_div_start;
    t_div_sts                  w_div_sts;
    logic [IDX_W-1:0]          w_div_idx;
    logic [BIN_W-1:0]          w_bin;
    logic [PIECE_W-1:0]        w_pbase;
    logic                      w_cnt_we;
    logic [BIN_W-1:0]          w_cnt_waddr;
    logic [CNT_W-1:0]          w_cnt_wdata, w_cnt_rd;
    logic                      w_pc_we;
    logic [PIECE_W-1:0]        w_pc_waddr, w_pc_raddr;
    logic [PW-1:0]             w_pc_wdata, w_pc_rd;
    logic signed [BB-1:0]      w_xl_e, w_xh_e, w_yl_e, w_yh_e;
    logic                      w_ov, w_full;
    logic signed [C-1:0]       w_cxlo, w_cxhi, w_cylo, w_cyhi;
    logic signed [C-1:0]       w_pxlo, w_pxhi, w_pylo, w_pyhi;
    logic [OWNER_BITS-1:0]     w_powner;
    logic                      w_qhit;
    logic                      w_in_acc, w_out_acc;
    logic                      w_o_load;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_ridx   = t_reg_idx'(paddr[4:2]);
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_die_x <= '0;
            r_die_y <= '0;
            r_bw    <= SIZE_BITS'(1);
            r_bh    <= SIZE_BITS'(1);
            r_grid  <= GRID_RESET;
        end else if (w_cfg_we) begin
            unique case (w_ridx)
                REG_DIE_X: r_die_x <= pwdata[C-1:0];
                REG_DIE_Y: r_die_y <= pwdata[C-1:0];
                REG_BIN_W: r_bw    <= pwdata[SIZE_BITS-1:0];
                REG_BIN_H: r_bh    <= pwdata[SIZE_BITS-1:0];
                REG_GRID:  r_grid  <= pwdata[GRID_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            REG_DIE_X: prdata = APB_DW'(r_die_x);
            REG_DIE_Y: prdata = APB_DW'(r_die_y);
            REG_BIN_W: prdata = APB_DW'(r_bw);
            REG_BIN_H: prdata = APB_DW'(r_bh);
            REG_GRID:  prdata = APB_DW'(r_grid);
            default:   prdata = '0;
        endcase
    end

    assign w_bw = (r_bw == '0) ? SIZE_BITS'(1) : r_bw;
    assign w_bh = (r_bh == '0) ? SIZE_BITS'(1) : r_bh;

    always_comb begin
        if (r_grid == '0) begin
            w_dim = DIM_W'(1);
        end else if (32'(r_grid) > MAX_GRID) begin
            w_dim = DIM_W'(MAX_GRID);
        end else begin
            w_dim = DIM_W'(r_grid);
        end
    end

    // ---------------- input beat and query center ----------------
    assign w_in_xl = s_axis_tdata[C-1:0];
    assign w_in_yl = s_axis_tdata[2*C-1:C];
    assign w_in_xh = s_axis_tdata[3*C-1:2*C];
    assign w_in_yh = s_axis_tdata[4*C-1:3*C];

    // truncate toward zero: bump negative sums by one before the halving
    assign w_sx  = (C+1)'(w_in_xl) + (C+1)'(w_in_xh);
    assign w_sy  = (C+1)'(w_in_yl) + (C+1)'(w_in_yh);
    assign w_sxr = w_sx + (C+1)'(w_sx[C]);
    assign w_syr = w_sy + (C+1)'(w_sy[C]);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;
    assign w_o_load      = (r_state == S_DONE) && (!r_o_valid || m_axis_tready);

    // ---------------- shared divider ----------------
    always_comb begin
        unique case (r_dsel)
            DS_XL:   w_dcoord = (r_cmd == CMD_QUERY) ? r_cx : r_xl;
            DS_XH:   w_dcoord = r_xh;
            DS_YL:   w_dcoord = (r_cmd == CMD_QUERY) ? r_cy : r_yl;
            DS_YH:   w_dcoord = r_yh;
            default: w_dcoord = r_xl;
        endcase
    end

    assign w_ddie      = r_dsel[1] ? r_die_y : r_die_x;
    assign w_dividend  = DW'(w_dcoord) - DW'(w_ddie);
    assign w_divisor   = r_dsel[1] ? w_bh : w_bw;
    assign w_div_start = (r_state == S_DIV);

    gboi_div #(
        .MAX_GRID (MAX_GRID),
        .DW       (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .i_dim      (w_dim),
        .o_sts      (w_div_sts),
        .o_index    (w_div_idx)
    );

    // ---------------- bin and piece addressing ----------------
    assign w_bin   = BIN_W'(r_r) * BIN_W'(MAX_GRID) + BIN_W'(r_c);
    assign w_pbase = PIECE_W'(w_bin) * PIECE_W'(SLOTS_PER_BIN);

    assign w_xl_e = BB'(r_xl);
    assign w_xh_e = BB'(r_xh);
    assign w_yl_e = BB'(r_yl);
    assign w_yh_e = BB'(r_yh);

    assign w_ov = (r_bx1 > w_xl_e) && (w_xh_e > r_bx0) && (r_xh > r_xl) &&
                  (r_by1 > w_yl_e) && (w_yh_e > r_by0) && (r_yh > r_yl);
    assign w_full = (w_cnt_rd >= CNT_W'(SLOTS_PER_BIN));

    // clip to the bin
    assign w_cxlo = (r_bx0 > w_xl_e) ? C'(r_bx0) : r_xl;
    assign w_cxhi = (r_bx1 < w_xh_e) ? C'(r_bx1) : r_xh;
    assign w_cylo = (r_by0 > w_yl_e) ? C'(r_by0) : r_yl;
    assign w_cyhi = (r_by1 < w_yh_e) ? C'(r_by1) : r_yh;

    assign w_pc_we    = (r_state == S_BWR) && w_ov && !w_full;
    assign w_pc_waddr = w_pbase + PIECE_W'(w_cnt_rd);
    assign w_pc_wdata = {r_owner, w_cyhi, w_cylo, w_cxhi, w_cxlo};
    assign w_pc_raddr = (r_state == S_QCHK) ? w_pbase + PIECE_W'(r_k) + PIECE_W'(1) : w_pbase;

    assign w_cnt_we    = (r_state == S_CLEAR) || w_pc_we;
    assign w_cnt_waddr = (r_state == S_CLEAR) ? r_clr : w_bin;
    assign w_cnt_wdata = (r_state == S_CLEAR) ? '0 : w_cnt_rd + CNT_W'(1);

    gboi_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NBINS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (w_bin),
        .o_rdata (w_cnt_rd)
    );

    gboi_ram #(
        .WIDTH (PW),
        .DEPTH (NPIECES)
    ) u_piece_ram (
        .i_clk   (i_clk),
        .i_we    (w_pc_we),
        .i_waddr (w_pc_waddr),
        .i_wdata (w_pc_wdata),
        .i_raddr (w_pc_raddr),
        .o_rdata (w_pc_rd)
    );

    assign w_pxlo   = w_pc_rd[C-1:0];
    assign w_pxhi   = w_pc_rd[2*C-1:C];
    assign w_pylo   = w_pc_rd[3*C-1:2*C];
    assign w_pyhi   = w_pc_rd[4*C-1:3*C];
    assign w_powner = w_pc_rd[PW-1:4*C];

    assign w_qhit = (r_xh > r_xl) && (r_xh > w_pxlo) && (w_pxhi > r_xl) && (w_pxhi > w_pxlo) &&
                    (r_yh > r_yl) && (r_yh > w_pylo) && (w_pyhi > r_yl) && (w_pyhi > w_pylo);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // load wins over a drain in the same cycle
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == BIN_W'(NBINS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd   <= s_axis_tuser[0];
                        r_xl    <= w_in_xl;
                        r_yl    <= w_in_yl;
                        r_xh    <= w_in_xh;
                        r_yh    <= w_in_yh;
                        r_owner <= s_axis_tdata[4*C+OWNER_BITS-1:4*C];
                        r_cx    <= w_sxr[C:1];
                        r_cy    <= w_syr[C:1];
                        r_hit   <= 1'b0;
                        r_who   <= '0;
                        r_ovf   <= 1'b0;
                        r_dsel  <= DS_XL;
                        if (s_axis_tuser[0] == CMD_QUERY && s_axis_tuser[1]) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_sts.done) begin
                        unique case (r_dsel)
                            DS_XL: begin
                                r_c0 <= w_div_idx;
                                r_c  <= w_div_idx;
                            end
                            DS_XH: r_c1 <= w_div_idx;
                            DS_YL: begin
                                r_r0 <= w_div_idx;
                                r_r  <= w_div_idx;
                            end
                            DS_YH: r_r1 <= w_div_idx;
                            default: ;
                        endcase
                        if (r_cmd == CMD_QUERY) begin
                            if (r_dsel == DS_YL) begin
                                r_state <= S_QRD;
                            end else begin
                                r_dsel  <= DS_YL;
                                r_state <= S_DIV;
                            end
                        end else if (r_dsel == DS_YH) begin
                            r_state <= S_BASE;
                        end else begin
                            r_dsel  <= r_dsel + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_BASE: begin
                    r_bx0s <= BB'(r_die_x) + BB'(r_c0) * BB'(w_bw);
                    r_bx0  <= BB'(r_die_x) + BB'(r_c0) * BB'(w_bw);
                    r_by0  <= BB'(r_die_y) + BB'(r_r0) * BB'(w_bh);
                    if (r_c0 > r_c1 || r_r0 > r_r1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BRD;
                    end
                end
                S_BRD: begin
                    r_bx1   <= r_bx0 + BB'(w_bw);
                    r_by1   <= r_by0 + BB'(w_bh);
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    if (w_ov && w_full) begin
                        r_ovf <= 1'b1;
                    end
                    // advance along the row, then wrap to the next row
                    if (r_c == r_c1) begin
                        if (r_r == r_r1) begin
                            r_state <= S_DONE;
                        end else begin
                            r_r     <= r_r + 1'b1;
                            r_c     <= r_c0;
                            r_bx0   <= r_bx0s;
                            r_by0   <= r_by0 + BB'(w_bh);
                            r_state <= S_BRD;
                        end
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_bx0   <= r_bx0 + BB'(w_bw);
                        r_state <= S_BRD;
                    end
                end
                S_QRD: begin
                    r_state <= S_QCNT;
                end
                S_QCNT: begin
                    r_k <= '0;
                    r_n <= w_full ? CNT_W'(SLOTS_PER_BIN) : w_cnt_rd;
                    if (w_cnt_rd == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_QCHK;
                    end
                end
                S_QCHK: begin
                    if (w_qhit) begin
                        r_hit   <= 1'b1;
                        r_who   <= w_powner;
                        r_state <= S_DONE;
                    end else if (r_k + 1'b1 == r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DONE: begin
                    if (w_o_load) begin
                        r_o_hit   <= r_hit;
                        r_o_who   <= r_who;
                        r_o_ovf   <= r_ovf;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DW'(r_o_who);
    assign m_axis_tuser  = {r_o_ovf, r_o_hit};

    `GBOI_ASSERT_IMP(a_piece_room, w_pc_we, w_cnt_rd < CNT_W'(SLOTS_PER_BIN))
    `GBOI_ASSERT_IMP(a_count_step, w_pc_we, w_cnt_wdata == w_cnt_rd + CNT_W'(1))
    `GBOI_ASSERT_IMP(a_hit_or_ovf, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `GBOI_ASSERT_IMP(a_clear_blocks, r_state == S_CLEAR, !s_axis_tready && !w_pc_we)
    `GBOI_ASSERT_IMP(a_div_quiet, r_state == S_IDLE, !w_div_sts.busy)

endmodule

/* test/grid_blockage_overlap_index_core_test.sv */
// Self-checking bench for grid_blockage_overlap_index_core: random and directed
// inserts and queries over stream ports, APB register phases. Depends on gboi_pkg and the core.
module grid_blockage_overlap_index_core_test;
    import gboi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX = 64;
    localparam int SLOTS    = 8;

    class overlap_scoreboard;
        // predictor state
        bit [3:0]        bin_fill [GRID_MAX*GRID_MAX];
        longint          px_lo [GRID_MAX*GRID_MAX*SLOTS];
        longint          px_hi [GRID_MAX*GRID_MAX*SLOTS];
        longint          py_lo [GRID_MAX*GRID_MAX*SLOTS];
        longint          py_hi [GRID_MAX*GRID_MAX*SLOTS];
        bit [15:0]       p_owner [GRID_MAX*GRID_MAX*SLOTS];
        longint          die_x, die_y, bin_w, bin_h;
        int unsigned     grid;
        bit [17:0]       expected_results [$];
        int              mismatches;

        function new();
            foreach (bin_fill[i]) bin_fill[i] = 0;
            die_x = 0; die_y = 0; bin_w = 1; bin_h = 1; grid = 50;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [31:0] v);
            case (idx)
                REG_DIE_X: die_x = longint'($signed(v));
                REG_DIE_Y: die_y = longint'($signed(v));
                REG_BIN_W: bin_w = longint'(v[30:0]);
                REG_BIN_H: bin_h = longint'(v[30:0]);
                REG_GRID:  grid  = v[6:0];
                default: ;
            endcase
        endfunction

        function int unsigned bin_of(longint off, longint sz, int unsigned dim);
            longint q;
            q = off / sz;
            if (q < 0) return 0;
            if (q >= dim) return dim - 1;
            return int'(q);
        endfunction

        function bit spans(longint a0, longint a1, longint b0, longint b1);
            longint hi, lo;
            hi = (a1 < b1) ? a1 : b1;
            lo = (a0 > b0) ? a0 : b0;
            return hi > lo;
        endfunction

        // predict and store the result of one accepted input beat
        function void note_item(bit cmd, bit macro, longint xl, longint yl,
                                longint xh, longint yh, bit [15:0] owner);
            int unsigned dim, c0, c1, r0, r1, bin, k, n;
            longint bw, bh, bx0, by0;
            bit hit, ovf;
            bit [15:0] who;
            dim = (grid < 1) ? 1 : ((grid > GRID_MAX) ? GRID_MAX : grid);
            bw = (bin_w < 1) ? 1 : bin_w;
            bh = (bin_h < 1) ? 1 : bin_h;
            hit = 0; ovf = 0; who = 0;
            if (cmd == CMD_INSERT) begin
                c0 = bin_of(xl - die_x, bw, dim);
                c1 = bin_of(xh - die_x, bw, dim);
                r0 = bin_of(yl - die_y, bh, dim);
                r1 = bin_of(yh - die_y, bh, dim);
                for (int unsigned r = r0; r <= r1; r++) begin
                    by0 = die_y + longint'(r) * bh;
                    for (int unsigned c = c0; c <= c1; c++) begin
                        bx0 = die_x + longint'(c) * bw;
                        bin = r * GRID_MAX + c;
                        if (!spans(bx0, bx0 + bw, xl, xh) || !spans(by0, by0 + bh, yl, yh))
                            continue;
                        if (bin_fill[bin] >= SLOTS) begin
                            ovf = 1;
                            continue;
                        end
                        k = bin * SLOTS + bin_fill[bin];
                        px_lo[k] = (bx0 > xl) ? bx0 : xl;
                        px_hi[k] = (bx0 + bw < xh) ? bx0 + bw : xh;
                        py_lo[k] = (by0 > yl) ? by0 : yl;
                        py_hi[k] = (by0 + bh < yh) ? by0 + bh : yh;
                        p_owner[k] = owner;
                        bin_fill[bin]++;
                    end
                end
            end else if (!macro) begin
                bin = bin_of((yl + yh) / 2 - die_y, bh, dim) * GRID_MAX
                    + bin_of((xl + xh) / 2 - die_x, bw, dim);
                n = bin_fill[bin];
                for (int unsigned i = 0; i < n; i++) begin
                    k = bin * SLOTS + i;
                    if (spans(xl, xh, px_lo[k], px_hi[k]) && spans(yl, yh, py_lo[k], py_hi[k])) begin
                        hit = 1;
                        who = p_owner[k];
                        break;
                    end
                end
            end
            expected_results.insert(expected_results.size(), {ovf, hit, who});
        endfunction

        function void check_result(bit [15:0] owner, bit hit, bit ovf);
            bit [17:0] exp_r;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: hit=%0b owner=%0h ovf=%0b",
                             hit, owner, ovf);
                return;
            end
            exp_r = expected_results.pop_front();
            if (exp_r != {ovf, hit, owner}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp hit=%0b owner=%0h ovf=%0b, got hit=%0b owner=%0h ovf=%0b",
                             exp_r[16], exp_r[15:0], exp_r[17], hit, owner, ovf);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [143:0]         s_axis_tdata = '0;  // x_low, y_low, x_high, y_high, owner_id
    logic [1:0]           s_axis_tuser = '0;  // command, is_macro
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;       // blocking_owner
    logic [1:0]           m_axis_tuser;       // hit, overflow

    grid_blockage_overlap_index_core DUT (.*);

    overlap_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: sample at rising edge, change ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(t_reg_idx idx, bit [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * int'(idx)); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_item(bit cmd, bit macro, int xl, int yl, int xh, int yh,
                             bit [15:0] owner);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {owner, yh, xh, yl, xl};
        s_axis_tuser  <= {macro, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(cmd, macro, xl, yl, xh, yh, owner);
    endtask

    task automatic go_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // die spread over the grid; most rectangles land inside it
    task automatic random_phase(int count, int dx, int dy, int bw, int bh, int dim);
        int span_x, span_y, xl, yl, xh, yh;
        bit cmd;
        span_x = bw * dim;
        span_y = bh * dim;
        for (int i = 0; i < count; i++) begin
            cmd = $urandom_range(99) < 55;
            if ($urandom_range(99) < 8) begin
                xl = $urandom; yl = $urandom; xh = $urandom; yh = $urandom;
            end else begin
                xl = dx - bw + int'($urandom_range(span_x + 2 * bw));
                yl = dy - bh + int'($urandom_range(span_y + 2 * bh));
                xh = xl + int'($urandom_range(cmd ? 3 * bw : 2 * bw)) - ($urandom_range(19) == 0);
                yh = yl + int'($urandom_range(cmd ? 3 * bh : 2 * bh)) - ($urandom_range(19) == 0);
            end
            send_item(cmd, $urandom_range(9) == 0, xl, yl, xh, yh, 16'($urandom));
        end
    endtask

    initial begin
        int pct_idle [4] = '{0, 52, 0, 26};
        int pct_stall[4] = '{0, 0, 52, 26};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: defaults, then a zero grid and an oversized grid
        send_item(CMD_QUERY, 1'b0, 0, 0, 2, 2, 16'h0);
        send_item(CMD_INSERT, 1'b0, 0, 0, 3, 3, 16'hffff);
        send_item(CMD_QUERY, 1'b0, 1, 1, 2, 2, 16'h0);
        send_item(CMD_QUERY, 1'b1, 1, 1, 2, 2, 16'h0);
        send_item(CMD_INSERT, 1'b0, 5, 5, 5, 9, 16'h1);   // degenerate
        send_item(CMD_INSERT, 1'b0, 9, 9, 7, 7, 16'h2);   // inverted
        for (int i = 0; i < 9; i++)
            send_item(CMD_INSERT, 1'b0, 10, 10, 11, 11, 16'(i + 3));  // fill one bin
        send_item(CMD_QUERY, 1'b0, 10, 10, 11, 11, 16'h0);
        send_item(CMD_INSERT, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h7fff_ffff, 16'h5a5a);
        send_item(CMD_QUERY, 1'b0, 32'h7fff_fff0, 32'h7fff_fff0, 32'h7fff_ffff,
                  32'h7fff_ffff, 16'h0);
        send_item(CMD_QUERY, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0010,
                  32'h8000_0010, 16'h0);
        send_item(CMD_QUERY, 1'b0, -7, -7, 2, 2, 16'h0);
        go_idle();

        write_reg(REG_GRID, 32'd0);
        write_reg(REG_BIN_W, 32'd0);
        write_reg(REG_BIN_H, 32'h7fff_ffff);
        write_reg(REG_DIE_X, 32'h8000_0000);
        write_reg(REG_DIE_Y, 32'h7fff_ffff);
        send_item(CMD_INSERT, 1'b0, -5, -5, 5, 5, 16'h77);
        send_item(CMD_QUERY, 1'b0, -1, -1, 1, 1, 16'h0);
        go_idle();
        write_reg(REG_GRID, 32'd127);
        send_item(CMD_QUERY, 1'b0, -3, -3, 1, 1, 16'h0);
        go_idle();

        for (int ph = 0; ph < 8; ph++) begin
            int bw, bh, dim, dx, dy;
            send_idle_pct  = pct_idle[ph % 4];
            recv_stall_pct = pct_stall[ph % 4];
            case (ph % 4)
                0: begin dim = 4;  bw = 10;   bh = 7;   end
                1: begin dim = 8;  bw = 100;  bh = 100; end
                2: begin dim = 64; bw = 3;    bh = 5;   end
                default: begin dim = 1 + $urandom_range(63); bw = 1 + $urandom_range(2000);
                    bh = 1 + $urandom_range(2000); end
            endcase
            dx = int'($urandom_range(200000)) - 100000;
            dy = (ph == 7) ? -2000000000 : int'($urandom_range(200000)) - 100000;
            write_reg(REG_DIE_X, dx);
            write_reg(REG_DIE_Y, dy);
            write_reg(REG_BIN_W, bw);
            write_reg(REG_BIN_H, bh);
            write_reg(REG_GRID, dim);
            random_phase(135, dx, dy, bw, bh, dim);
            go_idle();
        end

        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
